[rtl/atm_pkg.sv]
// atm_pkg: shared constants and types of the tone map unit
// curve coefficients, pipeline depth, stage enable type
// no dependencies
`default_nettype none
package atm_pkg;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned PRE_STAGES = 3;
  localparam int unsigned NUM_STAGES = PRE_STAGES + OUT_W;

  localparam int unsigned C_N2 = 251;
  localparam int unsigned C_N1 = 3;
  localparam int unsigned C_D2 = 243;
  localparam int unsigned C_D1 = 59;
  localparam int unsigned C_D0 = 14;

  typedef logic [NUM_STAGES-1:0] stage_en_t;
endpackage
`default_nettype wire

[rtl/atm_if.sv]
// channel interfaces of the tone map unit: pixel in, pixel out, exposure write
// valid/ready handshake, one word per accepted edge
// no dependencies
`default_nettype none
interface atm_pix_in_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface atm_pix_out_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface atm_cfg_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] exposure;
  modport source (output valid, exposure, input ready);
  modport sink (input valid, exposure, output ready);
endinterface
`default_nettype wire

[rtl/atm_lane.sv]
// atm_lane: one color channel, gain multiply, rational curve, 16-step divider
// depends on atm_pkg; stage enables come from atm_ctrl
`default_nettype none
module atm_lane #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 8
) (
  input  wire                               clk,
  input  wire atm_pkg::stage_en_t           en,
  input  wire [INT_BITS+FRAC_BITS-1:0]      pix,
  input  wire [INT_BITS+FRAC_BITS-1:0]      gain,
  output logic [atm_pkg::OUT_W-1:0]         res
);
  localparam int IW = INT_BITS + FRAC_BITS;
  localparam int PW = 2 * IW;
  localparam int XW = FRAC_BITS + 5;
  localparam int SW = 2 * XW;
  localparam int DW = 2 * FRAC_BITS + 16;
  localparam int NQ = atm_pkg::OUT_W;
  localparam int P  = atm_pkg::PRE_STAGES;

  logic [PW-1:0] prod_r;
  logic [XW-1:0] x_nxt, x_r;
  logic [SW-1:0] sq_r;
  logic [DW-1:0] num_nxt, den_nxt, num_r, den_r;
  logic          sat_r;

  logic [DW-1:0] rem_r [NQ];
  logic [DW-1:0] dv_r  [NQ];
  logic [NQ-1:0] q_r   [NQ];
  logic          st_r  [NQ];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= PW'(pix) * PW'(gain);
    end
  end

  assign x_nxt = (|prod_r[PW-1:2*FRAC_BITS+4]) ? (XW'(16) << FRAC_BITS)
                                               : XW'(prod_r[2*FRAC_BITS+3:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r  <= x_nxt;
      sq_r <= SW'(x_nxt) * SW'(x_nxt);
    end
  end

  assign num_nxt = DW'(atm_pkg::C_N2) * DW'(sq_r)
                 + ((DW'(atm_pkg::C_N1) * DW'(x_r)) << FRAC_BITS);
  assign den_nxt = DW'(atm_pkg::C_D2) * DW'(sq_r)
                 + ((DW'(atm_pkg::C_D1) * DW'(x_r)) << FRAC_BITS)
                 + (DW'(atm_pkg::C_D0) << (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      sat_r <= (num_nxt >= den_nxt);
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic [DW-1:0] rem_in, dv_in;
    logic [NQ-1:0] q_in;
    logic          st_in;
    logic [DW:0]   dbl;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num_r;
      assign dv_in  = den_r;
      assign q_in   = '0;
      assign st_in  = sat_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
      assign st_in  = st_r[k-1];
    end

    assign dbl  = {rem_in, 1'b0};
    assign take = (dbl >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en[P+k]) begin
        rem_r[k] <= take ? DW'(dbl - {1'b0, dv_in}) : DW'(dbl);
        dv_r[k]  <= dv_in;
        q_r[k]   <= {q_in[NQ-2:0], take};
        st_r[k]  <= st_in;
      end
    end
  end

  assign res = st_r[NQ-1] ? '1 : q_r[NQ-1];
endmodule
`default_nettype wire

[rtl/atm_ctrl.sv]
// atm_ctrl: valid tracking and per-stage advance for the lane pipelines
// bubbles collapse, so input is taken while a finished word waits
// depends on atm_pkg
`default_nettype none
module atm_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     out_ready,
  output logic                    in_ready,
  output logic                    out_valid,
  output atm_pkg::stage_en_t      en
);
  localparam int NS = atm_pkg::NUM_STAGES;

  logic [NS-1:0] vld_r, vld_nxt;

  assign en[NS-1] = !vld_r[NS-1] || out_ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end

  assign vld_nxt[0] = en[0] ? in_valid : vld_r[0];
  for (genvar i = 1; i < NS; i++) begin : g_vld
    assign vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

`ifndef ASSERT_OFF
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline valid not cleared by reset");
  a_in_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted word missing from first stage");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled output word dropped");
`endif
endmodule
`default_nettype wire

[rtl/aces_tone_map_rgb_unit.sv]
// aces_tone_map_rgb_unit: filmic tone map of one RGB pixel per word
// top level; depends on atm_pkg, atm_if, atm_lane, atm_ctrl
//
// in_pix carries red_in/green_in/blue_in, unsigned Q(INT_BITS).(FRAC_BITS).
// out_pix carries red_out/green_out/blue_out, unsigned Q0.16, 1.0 -> 65535.
// cfg_wr writes the exposure gain, same format as the inputs; always ready.
// Write it only while no pixel is in flight.
// Each channel: gain multiply, saturate at 16.0, rational curve, then a
// 16-stage restoring divider, one quotient bit per stage.
// A word accepted on in_pix passes through every stage register to out_pix.
// Throughput: one pixel per cycle unless out_pix stalls (pipelined divider).
// When out_pix stalls, empty stages still fill; in_pix.ready drops only
// once every stage holds a word. A stalled output word holds.
// Reset (rst_n low, synchronous) empties the pipeline and sets the
// exposure to 10.0.
`default_nettype none
module aces_tone_map_rgb_unit #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  atm_pix_in_if.sink   in_pix,
  atm_pix_out_if.source out_pix,
  atm_cfg_if.sink      cfg_wr
);
  localparam int IW = INT_BITS + FRAC_BITS;

  logic [IW-1:0]      exposure_r;
  atm_pkg::stage_en_t en;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r <= IW'(10) << FRAC_BITS;
    end else if (cfg_wr.valid) begin
      exposure_r <= cfg_wr.exposure;
    end
  end

  atm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .out_ready (out_pix.ready),
    .in_ready  (in_pix.ready),
    .out_valid (out_pix.valid),
    .en        (en)
  );

  atm_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_r (
    .clk (clk), .en (en), .pix (in_pix.red_in), .gain (exposure_r),
    .res (out_pix.red_out)
  );

  atm_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_g (
    .clk (clk), .en (en), .pix (in_pix.green_in), .gain (exposure_r),
    .res (out_pix.green_out)
  );

  atm_lane #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_lane_b (
    .clk (clk), .en (en), .pix (in_pix.blue_in), .gain (exposure_r),
    .res (out_pix.blue_out)
  );

`ifndef ASSERT_OFF
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr.valid |=> exposure_r == $past(cfg_wr.exposure))
    else $error("exposure write lost");
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr.valid |=> $stable(exposure_r))
    else $error("exposure changed without a write");
  a_rst_gain: assert property (@(posedge clk) !rst_n |=> exposure_r == (IW'(10) << FRAC_BITS))
    else $error("exposure not restored by reset");
`endif
endmodule
`default_nettype wire

[test/tb_aces_tone_map_rgb_unit.sv]
// tb_aces_tone_map_rgb_unit: random and directed test of the tone map unit
// predicts each output pixel with an exact rational curve and checks in order
// depends on atm_pkg, atm_if and the unit itself
`timescale 1ns / 100ps
`default_nettype none

module tb_aces_tone_map_rgb_unit;
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS = 8;
  localparam int IN_W = INT_BITS + FRAC_BITS;
  localparam int OUT_W = atm_pkg::OUT_W;
  localparam int LATENCY = atm_pkg::NUM_STAGES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [IN_W-1:0] EXPOSURE_RESET = 24'd655360;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } pixel_out_t;

  class tone_scoreboard;
    pixel_out_t pending[$];
    logic [IN_W-1:0] gain;
    int mismatches;

    function new();
      gain = EXPOSURE_RESET;
      mismatches = 0;
    endfunction

    function logic [OUT_W-1:0] map_channel(logic [IN_W-1:0] v);
      logic [63:0] x, num, den, rem, q, k, prod;
      k = 64'd1 << FRAC_BITS;
      if (gain == 0 || v == 0) x = 0;
      else begin
        prod = 64'(v) * 64'(gain);
        x = prod >> FRAC_BITS;
        if (x > (64'd16 << FRAC_BITS)) x = 64'd16 << FRAC_BITS;
      end
      num = x * (atm_pkg::C_N2 * x + atm_pkg::C_N1 * k);
      den = x * (atm_pkg::C_D2 * x + atm_pkg::C_D1 * k) + atm_pkg::C_D0 * k * k;
      if (num >= den) return 16'hFFFF;
      rem = num;
      q = 0;
      for (int i = 0; i < OUT_W; i++) begin
        q = q << 1;
        if (rem >= den - rem) begin
          rem = rem - (den - rem);
          q = q | 1;
        end else begin
          rem = rem + rem;
        end
      end
      return q[OUT_W-1:0];
    endfunction

    function void note_pixel(logic [IN_W-1:0] r, logic [IN_W-1:0] g, logic [IN_W-1:0] b);
      pixel_out_t p;
      p.red = map_channel(r);
      p.green = map_channel(g);
      p.blue = map_channel(b);
      pending.push_back(p);
    endfunction

    function void check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word r=%h g=%h b=%h",
                                       got.red, got.green, got.blue);
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  tone_scoreboard board;

  atm_pix_in_if #(IN_W) in_pix();
  atm_pix_out_if #(OUT_W) out_pix();
  atm_cfg_if #(IN_W) cfg_wr();

  aces_tone_map_rgb_unit #(.FRAC_BITS(FRAC_BITS), .INT_BITS(INT_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_pix(in_pix.sink), .out_pix(out_pix.source),
    .cfg_wr(cfg_wr.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_pix.valid = 1'b0;
    in_pix.red_in = '0;
    in_pix.green_in = '0;
    in_pix.blue_in = '0;
    out_pix.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.exposure = '0;
    board = new();
  end

  always @(posedge clk) begin
    if (rst_n) out_pix.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_pix.valid && out_pix.ready)
      board.check_pixel({out_pix.red_out, out_pix.green_out, out_pix.blue_out});
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_pixel(logic [IN_W-1:0] r, logic [IN_W-1:0] g, logic [IN_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid <= 1'b1;
    in_pix.red_in <= r;
    in_pix.green_in <= g;
    in_pix.blue_in <= b;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    board.note_pixel(r, g, b);
  endtask

  task automatic drain();
    in_pix.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_exposure(logic [IN_W-1:0] value);
    drain();
    cfg_wr.valid <= 1'b1;
    cfg_wr.exposure <= value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    board.gain = value;
  endtask

  function automatic logic [IN_W-1:0] rand_level();
    case ($urandom_range(3))
      0: return IN_W'($urandom_range(255));
      1: return IN_W'($urandom_range(65535));
      2: return IN_W'($urandom_range(24'h7FFFF));
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  initial begin
    logic [IN_W-1:0] gains[6];
    gains = '{24'd65536, 24'hFFFFFF, 24'd1, 24'd16384, 24'd200000, 24'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset, zero, full-scale and unity gains, extremes of each field
    send_pixel(0, 0, 0);
    send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(24'd1, 24'd65536, 24'hAAAAAA);
    send_pixel(24'h555555, 24'd47448, 24'd6554);
    send_pixel(24'd475000, 24'd0, 24'd104858);
    write_exposure(24'd0);
    send_pixel(24'hFFFFFF, 24'd65536, 24'd1);
    write_exposure(24'hFFFFFF);
    send_pixel(24'd1, 24'd2, 24'hFFFFFF);
    send_pixel(24'd16, 24'd17, 24'd255);
    write_exposure(24'd65536);
    send_pixel(24'd474000, 24'd1048576, 24'd1048577);
    send_pixel(24'd32768, 24'd13107, 24'd300);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (phase > 0) write_exposure(phase < 7 ? gains[phase - 1] : IN_W'($urandom));
      random_pixels(80);
      drain();
      random_pixels(75);
    end
    write_exposure(EXPOSURE_RESET);
    random_pixels(10);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire

[aces_tone_map_rgb_unit.f]
rtl/atm_pkg.sv
rtl/atm_if.sv
rtl/atm_lane.sv
rtl/atm_ctrl.sv
rtl/aces_tone_map_rgb_unit.sv
test/tb_aces_tone_map_rgb_unit.sv
